/* src/mbdc_pkg.sv */
// Types, codes and decode helpers shared by the memory bus decoder.
package mbdc_pkg;

  typedef enum logic [1:0] {
    ReqCpuRead  = 2'd0,
    ReqCpuWrite = 2'd1,
    ReqPpuRead  = 2'd2,
    ReqDmaCopy  = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    RgBank0  = 4'd0,
    RgBank1  = 4'd1,
    RgVram   = 4'd2,
    RgExtram = 4'd3,
    RgWram   = 4'd4,
    RgEcho   = 4'd5,
    RgOam    = 4'd6,
    RgUnused = 4'd7,
    RgIo     = 4'd8,
    RgHram   = 4'd9
  } region_e;

  typedef enum logic [2:0] {
    TgNone = 3'd0,
    TgCart = 3'd1,
    TgVram = 3'd2,
    TgWram = 3'd3,
    TgOam  = 3'd4,
    TgIo   = 3'd5,
    TgHram = 3'd6
  } target_e;

  typedef enum logic [1:0] {
    BusExt  = 2'd0,
    BusVram = 2'd1,
    BusNone = 2'd2
  } bus_e;

  localparam logic [1:0]  ModeOamSearch = 2'd2;
  localparam logic [1:0]  ModeDrawing   = 2'd3;
  localparam logic [15:0] OamBase       = 16'hFE00;
  localparam logic [7:0]  OamBytes      = 8'd160;
  localparam logic [15:0] EchoOffset    = 16'h2000;
  localparam logic [7:0]  ByteOpenBus   = 8'hFF;

  typedef struct packed {
    req_e        req;
    logic [15:0] address;
    logic [7:0]  dma_dest_offset;
    logic [7:0]  write_data;
    logic [1:0]  lcd_mode;
    logic        dma_active;
    logic [7:0]  target_data;
  } in_beat_t;

  typedef struct packed {
    region_e     region;
    target_e     read_target;
    logic [15:0] read_addr;
    target_e     write_target;
    logic [15:0] write_addr;
    logic [7:0]  write_value;
    logic [7:0]  read_value;
    logic        lcd_blocked;
    logic        dma_blocked;
  } out_beat_t;

  typedef struct packed {
    bus_e       bus;
    logic [7:0] last;
  } dma_st_t;

  typedef struct packed {
    logic    en;
    dma_st_t val;
  } dma_upd_t;

  function automatic region_e region_of(input logic [15:0] a);
    region_e rg;
    if (a < 16'h4000)                       rg = RgBank0;
    else if (a < 16'h8000)                  rg = RgBank1;
    else if (a < 16'hA000)                  rg = RgVram;
    else if (a < 16'hC000)                  rg = RgExtram;
    else if (a < 16'hE000)                  rg = RgWram;
    else if (a < 16'hFE00)                  rg = RgEcho;
    else if (a < 16'hFEA0)                  rg = RgOam;
    else if (a < 16'hFF00)                  rg = RgUnused;
    else if (a < 16'hFF80 || a == 16'hFFFF) rg = RgIo;
    else                                    rg = RgHram;
    return rg;
  endfunction

  function automatic target_e target_of(input region_e rg);
    target_e tg;
    case (rg)
      RgBank0, RgBank1, RgExtram: tg = TgCart;
      RgVram:                     tg = TgVram;
      RgWram, RgEcho:             tg = TgWram;
      RgOam:                      tg = TgOam;
      RgIo:                       tg = TgIo;
      RgHram:                     tg = TgHram;
      default:                    tg = TgNone;
    endcase
    return tg;
  endfunction

endpackage

/* src/memory_bus_decode_and_conflict_core.sv */
// Top level of the memory bus decoder: input register, decode, result register.
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+-----------------------------------
//   in      | in        | in_valid_i / in_stall_o      | req_type_i .. target_data_i
//   out     | out       | out_valid_o / out_stall_i    | region_o .. dma_blocked_o
//
// One beat per cycle sustained while out_stall_i stays low; a beat passes the input
// register, then one pass of decode and conflict logic into the result register.
// Reset clears both valid flags and puts the DMA state at bus not defined,
// last byte 0xFF. No clearing pass is needed.
// in_stall_o rises only while the input register holds a beat and the result
// register is full and stalled; a stalled result holds its value.
module memory_bus_decode_and_conflict_core import mbdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  dma_dest_offset_i,
  input  logic [7:0]  write_data_i,
  input  logic [1:0]  lcd_mode_i,
  input  logic        dma_active_i,
  input  logic [7:0]  target_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  region_o,
  output logic [2:0]  read_target_o,
  output logic [15:0] read_addr_o,
  output logic [2:0]  write_target_o,
  output logic [15:0] write_addr_o,
  output logic [7:0]  write_value_o,
  output logic [7:0]  read_value_o,
  output logic        lcd_blocked_o,
  output logic        dma_blocked_o
);

  logic      in_valid_q, out_valid_q;
  in_beat_t  in_q;
  out_beat_t out_q, res;
  dma_st_t   dma_st;
  dma_upd_t  upd;
  logic      out_free, advance, in_take;

  // Result register can load when empty or when its beat leaves now.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.req             <= req_e'(req_type_i);
      in_q.address         <= address_i;
      in_q.dma_dest_offset <= dma_dest_offset_i;
      in_q.write_data      <= write_data_i;
      in_q.lcd_mode        <= lcd_mode_i;
      in_q.dma_active      <= dma_active_i;
      in_q.target_data     <= target_data_i;
    end
  end

  mbdc_decode u_decode (
    .beat_i   (in_q),
    .dma_st_i (dma_st),
    .res_o    (res),
    .upd_o    (upd)
  );

  // Commit DMA state only when the copy beat moves into the result register.
  mbdc_dma_state u_dma_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance && upd.en),
    .st_i   (upd.val),
    .st_o   (dma_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign region_o       = out_q.region;
  assign read_target_o  = out_q.read_target;
  assign read_addr_o    = out_q.read_addr;
  assign write_target_o = out_q.write_target;
  assign write_addr_o   = out_q.write_addr;
  assign write_value_o  = out_q.write_value;
  assign read_value_o   = out_q.read_value;
  assign lcd_blocked_o  = out_q.lcd_blocked;
  assign dma_blocked_o  = out_q.dma_blocked;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result register can load");

  a_one_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(lcd_blocked_o && dma_blocked_o))
    else $error("both conflict flags set");

  a_ppu_block_no_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && lcd_blocked_o) |->
      (read_target_o == TgNone && write_target_o == TgNone))
    else $error("PPU-blocked access still selects a target");

  a_no_write_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && write_target_o == TgNone) |->
      (write_addr_o == 16'h0000 && write_value_o == 8'h00))
    else $error("dropped write carries address or data");

endmodule

/* src/mbdc_decode.sv */
// Region decode, target selection and conflict rules for one bus access.
module mbdc_decode import mbdc_pkg::*; (
  input  in_beat_t  beat_i,
  input  dma_st_t   dma_st_i,
  output out_beat_t res_o,
  output dma_upd_t  upd_o
);

  region_e     rg;
  target_e     tg;
  logic [15:0] maddr;
  logic        cart, dma_ext, dma_vram, ppu_vram, ppu_oam;
  logic        pc, dc;
  logic [7:0]  dma_byte;

  always_comb begin
    rg       = region_of(beat_i.address);
    tg       = target_of(rg);
    maddr    = (rg == RgEcho) ? beat_i.address - EchoOffset : beat_i.address;
    cart     = (tg == TgCart);
    dma_ext  = beat_i.dma_active && (dma_st_i.bus == BusExt);
    dma_vram = beat_i.dma_active && (dma_st_i.bus == BusVram);
    ppu_vram = (beat_i.lcd_mode == ModeDrawing);
    ppu_oam  = (beat_i.lcd_mode == ModeOamSearch) || (beat_i.lcd_mode == ModeDrawing);

    // CPU blocking: reads check DMA first, writes check the PPU first.
    pc = 1'b0;
    dc = 1'b0;
    if (cart) begin
      dc = dma_ext;
    end else if (rg == RgVram) begin
      if (beat_i.req == ReqCpuRead) begin
        dc = dma_vram;
        pc = !dma_vram && ppu_vram;
      end else begin
        pc = ppu_vram;
        dc = !ppu_vram && dma_vram;
      end
    end else if (rg == RgOam) begin
      if (beat_i.req == ReqCpuRead) begin
        dc = beat_i.dma_active;
        pc = !beat_i.dma_active && ppu_oam;
      end else begin
        pc = ppu_oam;
        dc = !ppu_oam && beat_i.dma_active;
      end
    end

    res_o              = '0;
    res_o.region       = rg;
    res_o.read_target  = TgNone;
    res_o.write_target = TgNone;
    res_o.read_value   = ByteOpenBus;
    upd_o              = '0;
    upd_o.val.bus      = BusNone;
    dma_byte           = ByteOpenBus;

    case (beat_i.req)
      ReqCpuRead: begin
        res_o.lcd_blocked = pc;
        res_o.dma_blocked = dc;
        if (dc) begin
          res_o.read_value = (rg == RgOam) ? ByteOpenBus : dma_st_i.last;
        end else if (!pc && tg != TgNone) begin
          res_o.read_target = tg;
          res_o.read_addr   = maddr;
          res_o.read_value  = beat_i.target_data;
        end
      end
      ReqCpuWrite: begin
        res_o.lcd_blocked = pc;
        res_o.dma_blocked = dc;
        res_o.read_value  = '0;
        if (!dc && !pc && tg != TgNone) begin
          res_o.write_target = tg;
          res_o.write_addr   = maddr;
          res_o.write_value  = beat_i.write_data;
        end
      end
      ReqPpuRead: begin
        if (rg == RgVram) begin
          if (dma_vram) begin
            res_o.dma_blocked = 1'b1;
            res_o.read_value  = dma_st_i.last;
          end else begin
            res_o.read_target = TgVram;
            res_o.read_addr   = beat_i.address;
            res_o.read_value  = beat_i.target_data;
          end
        end else if (rg == RgOam) begin
          if (beat_i.dma_active) begin
            res_o.dma_blocked = 1'b1;
          end else begin
            res_o.read_target = TgOam;
            res_o.read_addr   = beat_i.address;
            res_o.read_value  = beat_i.target_data;
          end
        end
      end
      default: begin
        // DMA copy: source read, OAM write, state update
        upd_o.en = 1'b1;
        if (cart || rg == RgVram || rg == RgWram) begin
          res_o.read_target = tg;
          res_o.read_addr   = beat_i.address;
          dma_byte          = beat_i.target_data;
        end
        if (cart)              upd_o.val.bus = BusExt;
        else if (rg == RgVram) upd_o.val.bus = BusVram;
        upd_o.val.last   = dma_byte;
        res_o.read_value = dma_byte;
        if (beat_i.dma_dest_offset < OamBytes) begin
          res_o.write_target = TgOam;
          res_o.write_addr   = OamBase + {8'h00, beat_i.dma_dest_offset};
          res_o.write_value  = dma_byte;
        end
      end
    endcase
  end

endmodule

/* src/mbdc_dma_state.sv */
// DMA source bus and last copied byte, updated by each DMA copy beat.
module mbdc_dma_state import mbdc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  dma_st_t  st_i,
  output dma_st_t  st_o
);

  dma_st_t st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.bus  <= BusNone;
      st_q.last <= ByteOpenBus;
    end else if (en_i) begin
      st_q <= st_i;
    end
  end

  assign st_o = st_q;

endmodule
